### hw/rtl/selective_repeat_sender_window_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat sender window unit
// Implication and next-cycle implication forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication
`define SRSW_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRSW_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants, codes and types of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int MAX_FRAMES_DEF = 256;
	localparam int MAX_WINDOW_DEF = 8;

	localparam int TOTAL_W    = 9;
	localparam int WINDOW_W   = 4;
	localparam int CMD_W      = 2;
	localparam int SEQ_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 9'd8;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_NACK    = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SLIDE_RD,
		ST_SLIDE_CHK,
		ST_SEND_INIT,
		ST_SEND,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             frame_valid;
		logic [SEQ_W-1:0] frame_number;
		logic             parity_bit;
		logic             is_resend;
		logic             bad_number;
		logic             transfer_done;
		logic             last;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic count;
	} cur_ctl_t;

endpackage

### hw/rtl/srsw_if.sv
// ----------------------------------------------------------------------------
// srsw channel interfaces
// Event input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface srsw_evt_if;
	import srsw_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [SEQ_W-1:0]    seq_number;

	modport source (output valid, output command, output seq_number, input ready);
	modport sink (input valid, input command, input seq_number, output ready);
endinterface

interface srsw_res_if;
	import srsw_pkg::*;

	logic             valid;
	logic             ready;
	logic             frame_valid;
	logic [SEQ_W-1:0] frame_number;
	logic             parity_bit;
	logic             is_resend;
	logic             bad_number;
	logic             transfer_done;
	logic             last;

	modport source (
		output valid, output frame_valid, output frame_number, output parity_bit,
		output is_resend, output bad_number, output transfer_done, output last,
		input ready
	);
	modport sink (
		input valid, input frame_valid, input frame_number, input parity_bit,
		input is_resend, input bad_number, input transfer_done, input last,
		output ready
	);
endinterface

interface srsw_cfg_if;
	import srsw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/srsw_ack_ram.sv
// ----------------------------------------------------------------------------
// srsw_ack_ram
// Acked bitmap, one bit per frame; one write and one registered read port.
// ----------------------------------------------------------------------------
module srsw_ack_ram #(
	parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_FRAMES)-1:0] wr_addr,
	input  logic                          wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_FRAMES)-1:0] rd_addr,
	output logic                          rd_data
);
	logic mem [0:MAX_FRAMES-1];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

### hw/rtl/srsw_cursor.sv
// ----------------------------------------------------------------------------
// srsw_cursor
// Shared frame cursor: increment, compare against bound, count emitted frames.
// ----------------------------------------------------------------------------
module srsw_cursor #(
	parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srsw_pkg::cur_ctl_t              ctl,
	input  logic [$clog2(MAX_FRAMES+1)-1:0] cur_load,
	input  logic [$clog2(MAX_FRAMES+1)-1:0] bound_load,
	output logic [$clog2(MAX_FRAMES+1)-1:0] cur,
	output logic [$clog2(MAX_FRAMES+1)-1:0] cur_inc,
	output logic                            more,
	output logic                            room
);
	import srsw_pkg::*;

	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int KW = $clog2(MAX_WINDOW + 1);

	logic [CW-1:0] cur_q;
	logic [CW-1:0] bound_q;
	logic [KW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			bound_q <= '0;
			cnt_q   <= '0;
		end else if (ctl.load) begin
			cur_q   <= cur_load;
			bound_q <= bound_load;
			cnt_q   <= '0;
		end else if (ctl.step) begin
			cur_q <= cur_inc;
			if (ctl.count) begin
				cnt_q <= KW'(cnt_q + KW'(1));
			end
		end
	end

	assign cur     = cur_q;
	assign cur_inc = CW'(cur_q + CW'(1));
	assign more    = cur_q < bound_q;
	assign room    = cnt_q < KW'(MAX_WINDOW);
endmodule

### hw/rtl/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Window state and event sequencer; holds one result back to tag the last.
// ----------------------------------------------------------------------------
module srsw_ctrl #(
	parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [srsw_pkg::TOTAL_W-1:0]    frame_total,
	input  logic [srsw_pkg::WINDOW_W-1:0]   window_len,
	srsw_evt_if.sink                        evt,
	output logic                            res_push,
	output srsw_pkg::result_t               res_data,
	input  logic                            res_free,
	output srsw_pkg::cur_ctl_t              cur_ctl,
	output logic [$clog2(MAX_FRAMES+1)-1:0] cur_load,
	output logic [$clog2(MAX_FRAMES+1)-1:0] bound_load,
	input  logic [$clog2(MAX_FRAMES+1)-1:0] cur,
	input  logic [$clog2(MAX_FRAMES+1)-1:0] cur_inc,
	input  logic                            more,
	input  logic                            room,
	output logic                            ram_wr_en,
	output logic [$clog2(MAX_FRAMES)-1:0]   ram_wr_addr,
	output logic                            ram_wr_data,
	output logic                            ram_rd_en,
	output logic [$clog2(MAX_FRAMES)-1:0]   ram_rd_addr,
	input  logic                            ram_rd_data
);
	import srsw_pkg::*;

	localparam int CW  = $clog2(MAX_FRAMES + 1);
	localparam int AW  = $clog2(MAX_FRAMES);
	localparam int EW  = (CW > TOTAL_W) ? CW : TOTAL_W;
	localparam int MWW = $clog2(MAX_WINDOW + 1);
	localparam int VW  = (MWW > WINDOW_W) ? MWW : WINDOW_W;
	localparam int LW  = $clog2(MAX_FRAMES + MAX_WINDOW + 1);

	state_t          state_q, state_d;
	cmd_t            cmd_q;
	logic [SEQ_W-1:0] n_q;
	logic            bad_q;
	logic [CW-1:0]   base_q;
	logic [CW-1:0]   next_q;
	result_t         pend_q;
	logic            pend_v_q;

	logic [EW-1:0]   tot_raw_e, tot_e, n_e;
	logic [CW-1:0]   tot_c, slide_bound, send_bound;
	logic [VW-1:0]   ws_e, win_e;
	logic [LW-1:0]   limit_l, tot_l;
	logic            bad, early, done;
	logic            gen, stall, flush, base_set, next_set, nack_load, bad_set;
	result_t         gen_res, status;

	function automatic result_t mk_frame(input logic [CW-1:0] f, input logic resend);
		result_t       r;
		logic [EW-1:0] fe;
		fe             = EW'(f);
		r              = '0;
		r.frame_valid  = 1'b1;
		r.frame_number = fe[SEQ_W-1:0];
		r.parity_bit   = fe[0];
		r.is_resend    = resend;
		return r;
	endfunction

	// effective total and window
	assign tot_raw_e = EW'(frame_total);
	assign tot_e     = (tot_raw_e > EW'(MAX_FRAMES)) ? EW'(MAX_FRAMES) : tot_raw_e;
	assign tot_c     = tot_e[CW-1:0];
	assign ws_e      = VW'(window_len);
	assign win_e     = (ws_e == '0) ? VW'(1) :
	                   ((ws_e > VW'(MAX_WINDOW)) ? VW'(MAX_WINDOW) : ws_e);
	assign limit_l   = LW'(base_q) + LW'(win_e);
	assign tot_l     = LW'(tot_c);
	assign send_bound  = (limit_l < tot_l) ? limit_l[CW-1:0] : tot_c;
	assign slide_bound = (next_q < tot_c) ? next_q : tot_c;

	assign n_e   = EW'(n_q);
	assign bad   = n_e >= tot_e;
	assign early = n_e >= EW'(next_q);
	assign done  = EW'(base_q) >= tot_e;
	assign stall = pend_v_q && !res_free;

	assign evt.ready = (state_q == ST_IDLE);

	always_comb begin
		status            = '0;
		status.bad_number = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cur_ctl     = '0;
		cur_load    = base_q;
		bound_load  = next_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = n_e[AW-1:0];
		ram_wr_data = 1'b1;
		ram_rd_en   = 1'b0;
		ram_rd_addr = cur[AW-1:0];
		gen         = 1'b0;
		gen_res     = mk_frame(cur, 1'b0);
		flush       = 1'b0;
		base_set    = 1'b0;
		next_set    = 1'b0;
		nack_load   = 1'b0;
		bad_set     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (evt.valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (cmd_q)
					CMD_START: begin
						state_d = ST_SEND_INIT;
					end
					CMD_ACK, CMD_NACK: begin
						if (bad) begin
							bad_set = 1'b1;
							state_d = ST_FLUSH;
						end else if (early) begin
							state_d = ST_FLUSH;
						end else if (cmd_q == CMD_ACK) begin
							ram_wr_en   = 1'b1;
							cur_ctl.load = 1'b1;
							bound_load  = slide_bound;
							state_d     = ST_SLIDE_RD;
						end else begin
							nack_load = 1'b1;
							state_d   = ST_FLUSH;
						end
					end
					CMD_TIMEOUT: begin
						cur_ctl.load = 1'b1;
						state_d      = ST_SCAN_RD;
					end
				endcase
			end
			ST_SLIDE_RD: begin
				if (more) begin
					ram_rd_en = 1'b1;
					state_d   = ST_SLIDE_CHK;
				end else begin
					base_set = 1'b1;
					state_d  = ST_SEND_INIT;
				end
			end
			ST_SLIDE_CHK: begin
				if (ram_rd_data) begin
					cur_ctl.step = 1'b1;
					state_d      = ST_SLIDE_RD;
				end else begin
					base_set = 1'b1;
					state_d  = ST_SEND_INIT;
				end
			end
			ST_SEND_INIT: begin
				cur_ctl.load = 1'b1;
				cur_load     = next_q;
				bound_load   = send_bound;
				state_d      = ST_SEND;
			end
			ST_SEND: begin
				if (more && room) begin
					gen = 1'b1;
					if (!stall) begin
						// fresh frame: its acked bit starts cleared
						ram_wr_en     = 1'b1;
						ram_wr_addr   = cur[AW-1:0];
						ram_wr_data   = 1'b0;
						cur_ctl.step  = 1'b1;
						cur_ctl.count = 1'b1;
						next_set      = 1'b1;
					end
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_SCAN_RD: begin
				if (more && room) begin
					ram_rd_en = 1'b1;
					state_d   = ST_SCAN_CHK;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_SCAN_CHK: begin
				if (!ram_rd_data) begin
					gen     = 1'b1;
					gen_res = mk_frame(cur, 1'b1);
					if (!stall) begin
						cur_ctl.step  = 1'b1;
						cur_ctl.count = 1'b1;
						state_d       = ST_SCAN_RD;
					end
				end else begin
					cur_ctl.step = 1'b1;
					state_d      = ST_SCAN_RD;
				end
			end
			ST_FLUSH: begin
				flush = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_push = (gen && pend_v_q && res_free) || (flush && res_free);
		if (flush) begin
			res_data = pend_v_q ? pend_q : status;
		end else begin
			res_data = pend_q;
		end
		res_data.last          = flush;
		res_data.transfer_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= '0;
			bad_q    <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				bad_q <= 1'b0;
			end else if (bad_set) begin
				bad_q <= 1'b1;
			end
			if (base_set) begin
				base_q <= cur;
			end
			if (next_set) begin
				next_q <= cur_inc;
			end
			if (nack_load || (gen && !stall)) begin
				pend_v_q <= 1'b1;
			end else if (flush && res_free) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && evt.valid) begin
			cmd_q <= cmd_t'(evt.command);
			n_q   <= evt.seq_number;
		end
		if (nack_load) begin
			pend_q <= mk_frame(n_e[CW-1:0], 1'b1);
		end else if (gen && !stall) begin
			pend_q <= gen_res;
		end
	end
endmodule

### hw/rtl/selective_repeat_sender_window_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender side of a selective-repeat ARQ window: start, ack, nack, timeout.
//
//   channel  dir  handshake     transaction
//   evt      in   valid/ready   command, seq_number
//   res      out  valid/ready   one frame or status result, last on the final
//   cfg      in   valid/ready   index 0 frame total, index 1 window length
//
// evt.ready stays low from acceptance until the event is finished: bad, early or
// nack flush one result; start sends the new frames the window allows; timeout
// rescans outstanding frames and resends unacked ones; ack slides the base past
// acked frames, then sends new ones, all through the shared frame cursor and the single read port of the acked bitmap.
// A held result stalls the sequencer until res.ready frees the output slot.
// After reset the bitmap is not swept; each bit is cleared as its frame is sent.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
	parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	srsw_evt_if.sink    evt,
	srsw_res_if.source  res,
	srsw_cfg_if.sink    cfg
);
	import srsw_pkg::*;

	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int AW = $clog2(MAX_FRAMES);

	logic [TOTAL_W-1:0]  total_q;
	logic [WINDOW_W-1:0] window_q;
	result_t             res_q;
	logic                res_v_q;
	logic                res_free;
	logic                res_push;
	result_t             res_data;
	cur_ctl_t            cur_ctl;
	logic [CW-1:0]       cur_load, bound_load, cur, cur_inc;
	logic                more, room;
	logic                ram_wr_en, ram_wr_data, ram_rd_en, ram_rd_data;
	logic [AW-1:0]       ram_wr_addr, ram_rd_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TOTAL_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TOTAL:  total_q  <= cfg.data[TOTAL_W-1:0];
				REG_WINDOW: window_q <= cfg.data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	assign res_free = !res_v_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_push) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res_data;
		end
	end

	assign res.valid         = res_v_q;
	assign res.frame_valid   = res_q.frame_valid;
	assign res.frame_number  = res_q.frame_number;
	assign res.parity_bit    = res_q.parity_bit;
	assign res.is_resend     = res_q.is_resend;
	assign res.bad_number    = res_q.bad_number;
	assign res.transfer_done = res_q.transfer_done;
	assign res.last          = res_q.last;

	srsw_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_total  (total_q),
		.window_len   (window_q),
		.evt          (evt),
		.res_push     (res_push),
		.res_data     (res_data),
		.res_free     (res_free),
		.cur_ctl      (cur_ctl),
		.cur_load     (cur_load),
		.bound_load   (bound_load),
		.cur          (cur),
		.cur_inc      (cur_inc),
		.more         (more),
		.room         (room),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (ram_rd_data)
	);

	srsw_cursor #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_WINDOW (MAX_WINDOW)
	) u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cur_ctl),
		.cur_load   (cur_load),
		.bound_load (bound_load),
		.cur        (cur),
		.cur_inc    (cur_inc),
		.more       (more),
		.room       (room)
	);

	srsw_ack_ram #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ack_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);
endmodule

### hw/rtl/srsw_checker.sv
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_unit_assert.svh"

module srsw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       evt_valid,
	input logic                       evt_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       res_last,
	input logic [srsw_pkg::SEQ_W-1:0] res_frame_number
);
	// one event at a time
	`SRSW_ASSERT_NXT(a_evt_busy, clk, arst_n, evt_valid && evt_ready, !evt_ready, "event taken while busy")

	// the sequencer goes idle only as the final result is loaded
	`SRSW_ASSERT_IMP(a_idle_after_last, clk, arst_n, $rose(evt_ready), res_valid && res_last, "idle without final result")

	// a stalled result holds
	`SRSW_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_last) && $stable(res_frame_number), "stalled result changed")
endmodule

bind selective_repeat_sender_window_unit srsw_checker u_srsw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.evt_valid        (evt.valid),
	.evt_ready        (evt.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_last         (res.last),
	.res_frame_number (res.frame_number)
);

### tb/tb_selective_repeat_sender_window_unit.sv
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window_unit
// Drives start, ack, nack and timeout events into the sender window with random
// gaps and output stalls, predicts every frame and status transaction from an
// independent model of the window, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import srsw_pkg::*;

	logic clk;
	logic arst_n;

	srsw_evt_if evt_ch ();
	srsw_res_if res_ch ();
	srsw_cfg_if cfg_ch ();

	selective_repeat_sender_window_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// window model state
	logic [TOTAL_W-1:0]  total_reg;
	logic [WINDOW_W-1:0] window_reg;
	int                  win_base;
	int                  next_seq;
	bit                  acked [MAX_FRAMES_DEF];

	result_t expected_frames [$];

	int errors;
	int events_sent;
	int results_seen;
	int new_frames;
	int resent_frames;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int eff_total();
		return (total_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(total_reg);
	endfunction

	function automatic int eff_window();
		if (window_reg == 0)
			return 1;
		return (window_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(window_reg);
	endfunction

	function automatic result_t make_result(bit fv, int num, bit resend, bit bad);
		result_t r;
		r = '0;
		r.frame_valid  = fv;
		r.frame_number = fv ? num[SEQ_W-1:0] : '0;
		r.parity_bit   = fv ? num[0] : 1'b0;
		r.is_resend    = resend;
		r.bad_number   = bad;
		return r;
	endfunction

	task automatic send_new_frames(ref result_t batch [$]);
		int limit;
		limit = win_base + eff_window();
		while (next_seq < eff_total() && next_seq < limit && batch.size() < MAX_WINDOW_DEF) begin
			batch.push_back(make_result(1'b1, next_seq, 1'b0, 1'b0));
			next_seq++;
			new_frames++;
		end
	endtask

	task automatic advance_window(input cmd_t cmd, input logic [SEQ_W-1:0] seq);
		result_t batch [$];
		result_t r;
		int      total;
		int      n;
		total = eff_total();
		n = int'(seq);
		case (cmd)
			CMD_START: begin
				send_new_frames(batch);
			end
			CMD_ACK, CMD_NACK: begin
				if (n >= total) begin
					batch.push_back(make_result(1'b0, 0, 1'b0, 1'b1));
				end else if (n >= next_seq) begin
					batch.push_back(make_result(1'b0, 0, 1'b0, 1'b0));
				end else if (cmd == CMD_ACK) begin
					acked[n] = 1'b1;
					while (win_base < total && win_base < MAX_FRAMES_DEF && acked[win_base])
						win_base++;
					send_new_frames(batch);
				end else begin
					batch.push_back(make_result(1'b1, n, 1'b1, 1'b0));
					resent_frames++;
				end
			end
			default: begin
				for (int f = win_base; f < next_seq && f < MAX_FRAMES_DEF
						&& batch.size() < MAX_WINDOW_DEF; f++) begin
					if (!acked[f]) begin
						batch.push_back(make_result(1'b1, f, 1'b1, 1'b0));
						resent_frames++;
					end
				end
			end
		endcase
		if (batch.size() == 0)
			batch.push_back(make_result(1'b0, 0, 1'b0, 1'b0));
		foreach (batch[i]) begin
			r = batch[i];
			r.transfer_done = (win_base >= eff_total());
			r.last = (i == batch.size() - 1);
			expected_frames.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_event(input cmd_t cmd, input logic [SEQ_W-1:0] seq);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			evt_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid      = 1'b1;
		evt_ch.command    = cmd;
		evt_ch.seq_number = seq;
		forever begin
			@(posedge clk);
			if (evt_ch.ready)
				break;
		end
		advance_window(cmd, seq);
		events_sent++;
	endtask

	task automatic idle_events();
		@(negedge clk);
		evt_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_frames.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		idle_events();
		wait_drained();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		forever begin
			@(posedge clk);
			if (cfg_ch.ready)
				break;
		end
		if (idx == REG_TOTAL)
			total_reg = value;
		else if (idx == REG_WINDOW)
			window_reg = value[WINDOW_W-1:0];
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [SEQ_W-1:0] any_seq();
		return SEQ_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [SEQ_W-1:0] outstanding_seq();
		return SEQ_W'(win_base + $urandom_range(0, next_seq - win_base - 1));
	endfunction

	task automatic random_event();
		int r;
		r = $urandom_range(0, 99);
		if (next_seq <= win_base && r < 65)
			send_event(CMD_START, any_seq());
		else if (r < 55)
			send_event(CMD_ACK, outstanding_seq());
		else if (r < 65)
			send_event(CMD_NACK, outstanding_seq());
		else if (r < 73)
			send_event(CMD_TIMEOUT, any_seq());
		else if (r < 80)
			send_event(CMD_START, any_seq());
		else
			send_event(cmd_t'($urandom_range(0, 3)), any_seq());
	endtask

	function automatic void check_field(string name, logic [SEQ_W-1:0] exp,
			logic [SEQ_W-1:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, actual %0d", name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_frames.size() == 0) begin
				$error("unexpected result transaction: frame_number %0d", res_ch.frame_number);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				check_field("frame_valid", want.frame_valid, res_ch.frame_valid);
				check_field("frame_number", want.frame_number, res_ch.frame_number);
				check_field("parity_bit", want.parity_bit, res_ch.parity_bit);
				check_field("is_resend", want.is_resend, res_ch.is_resend);
				check_field("bad_number", want.bad_number, res_ch.bad_number);
				check_field("transfer_done", want.transfer_done, res_ch.transfer_done);
				check_field("last", want.last, res_ch.last);
			end
		end
	end

	// output backpressure: calm stretches, short stalls, a few long ones
	initial begin
		int hold;
		int calm;
		int r;
		res_ch.ready = 1'b0;
		hold = 0;
		calm = 0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				res_ch.ready = 1'b1;
				calm--;
			end else if (hold > 0) begin
				res_ch.ready = 1'b0;
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					calm = $urandom_range(10, 60);
					res_ch.ready = 1'b1;
				end else if (r < 14) begin
					hold = $urandom_range(15, 40);
					res_ch.ready = 1'b0;
				end else if (r < 40) begin
					hold = $urandom_range(0, 3);
					res_ch.ready = 1'b0;
				end else begin
					res_ch.ready = 1'b1;
				end
			end
		end
	end

	task automatic test_default_window();
		send_event(CMD_START, 8'hFF);
		send_event(CMD_ACK, 8'd1);
		send_event(CMD_ACK, 8'd0);
		send_event(CMD_NACK, 8'd3);
		send_event(CMD_NACK, 8'd1);
		send_event(CMD_TIMEOUT, 8'hAA);
		send_event(CMD_ACK, 8'd7);
		send_event(CMD_ACK, 8'd8);
		send_event(CMD_NACK, 8'd255);
		send_event(CMD_ACK, 8'd0);
		send_event(CMD_START, 8'h55);
		for (int f = 2; f < 8; f++)
			send_event(CMD_ACK, SEQ_W'(f));
		send_event(CMD_TIMEOUT, 8'h00);
		send_event(CMD_NACK, 8'd2);
	endtask

	task automatic test_window_limits();
		write_register(REG_TOTAL, 9'd24);
		write_register(REG_WINDOW, 9'd0);
		send_event(CMD_START, 8'd0);
		send_event(CMD_ACK, 8'd8);
		send_event(CMD_TIMEOUT, 8'd0);
		write_register(REG_WINDOW, 9'd15);
		send_event(CMD_START, 8'd0);
		send_event(CMD_ACK, 8'd9);
		send_event(CMD_TIMEOUT, 8'd0);
	endtask

	task automatic test_total_limits();
		write_register(REG_TOTAL, 9'd0);
		send_event(CMD_START, 8'd0);
		send_event(CMD_ACK, 8'd0);
		send_event(CMD_NACK, 8'd5);
		send_event(CMD_TIMEOUT, 8'd0);
		write_register(REG_TOTAL, 9'd511);
		send_event(CMD_START, 8'd0);
		send_event(CMD_ACK, 8'd128);
	endtask

	task automatic test_random_traffic();
		int windows [4];
		windows = '{1, 8, 15, $urandom_range(2, 7)};
		foreach (windows[w]) begin
			write_register(REG_WINDOW, CFG_DATA_W'(windows[w]));
			if (w == 2)
				write_register(REG_TOTAL, 9'd256);
			repeat (15)
				random_event();
		end
	endtask

	task automatic test_transfer_completion();
		int guard;
		write_register(REG_TOTAL, CFG_DATA_W'((next_seq + 3 > 256) ? 256 : next_seq + 3));
		write_register(REG_WINDOW, 9'd8);
		guard = 0;
		while (win_base < eff_total() && guard < 200) begin
			if (next_seq <= win_base)
				send_event(CMD_START, any_seq());
			else
				send_event(CMD_ACK, outstanding_seq());
			guard++;
		end
		send_event(CMD_TIMEOUT, any_seq());
		send_event(CMD_START, any_seq());
		write_register(REG_TOTAL, 9'd1);
		send_event(CMD_ACK, 8'd0);
		send_event(CMD_NACK, 8'd1);
	endtask

	initial begin
		errors        = 0;
		events_sent   = 0;
		results_seen  = 0;
		new_frames    = 0;
		resent_frames = 0;
		total_reg     = TOTAL_RESET;
		window_reg    = WINDOW_RESET;
		win_base      = 0;
		next_seq      = 0;
		foreach (acked[i])
			acked[i] = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.command    = CMD_START;
		evt_ch.seq_number = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_TOTAL;
		cfg_ch.data       = '0;
		arst_n            = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_default_window();
		test_window_limits();
		test_total_limits();
		test_random_traffic();
		test_transfer_completion();

		idle_events();
		wait_drained();
		repeat (40) @(posedge clk);
		$display("Ran %0d events through the window, %0d result transactions checked.",
			events_sent, results_seen);
		$display("Frames predicted: %0d new, %0d resent; window base ended at %0d.",
			new_frames, resent_frames, win_base);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
